// ===== rtl/core/diluted_ising_metropolis_update_unit_assert.svh =====
// assertion macros for the ising update unit and its checker
// no dependencies; include once per file that asserts
`ifndef DILUTED_ISING_METROPOLIS_UPDATE_UNIT_ASSERT_SVH
`define DILUTED_ISING_METROPOLIS_UPDATE_UNIT_ASSERT_SVH

// property holds at every clock edge outside reset
`define DIMU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define DIMU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/dimu_pkg.sv =====
// shared constants, codes and types of the ising update unit
// no dependencies
`timescale 1ns / 1ps

package dimu_pkg;

  localparam int unsigned SIDE   = 128;
  localparam int unsigned NSITES = SIDE * SIDE;
  localparam int unsigned ADDR_W = $clog2(NSITES);
  localparam int unsigned RC_W   = $clog2(SIDE);

  localparam int unsigned REQ_W  = 2;
  localparam int unsigned SITE_W = 14;
  localparam int unsigned SPIN_W = 2;
  localparam int unsigned SLOT_W = 5;
  localparam int unsigned THR_W  = 17;
  localparam int unsigned RND_W  = 16;
  localparam int unsigned NSUM_W = 4;
  localparam int unsigned MAG_W  = 16;

  localparam int unsigned NSLOTS = 18;
  localparam logic [THR_W-1:0] THR_ONE = THR_W'(65536);

  // row = (site * RECIP) >> RECIP_SHIFT, exact for 16-bit sites and SIDE up to 256
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned RECIP_W     = 23;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << RECIP_SHIFT) / SIDE + 1);
  localparam int unsigned PROD_W      = SITE_W + RECIP_W;

  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TABLE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_FLIP  = 2'd3;

  localparam int unsigned STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_CTR   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_RIGHT = 3'd1;
  localparam logic [STEP_W-1:0] STEP_LEFT  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_UP    = 3'd3;
  localparam logic [STEP_W-1:0] STEP_DOWN  = 3'd4;

  typedef struct packed {
    logic              div_en;
    logic              col_en;
    logic [STEP_W-1:0] step;
  } addr_ctl_t;

endpackage

// ===== rtl/core/dimu_ram.sv =====
// generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module dimu_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

// ===== rtl/core/dimu_nbr_addr.sv =====
// site to row and column split and wrapped neighbour address generation
// depends on dimu_pkg
`timescale 1ns / 1ps

module dimu_nbr_addr (
  input  logic                              clk_i,
  input  dimu_pkg::addr_ctl_t               ctl_i,
  input  logic [dimu_pkg::SITE_W-1:0]       site_i,
  output logic [dimu_pkg::ADDR_W-1:0]       addr_o
);

  logic [dimu_pkg::PROD_W-1:0] prod;
  logic [dimu_pkg::RC_W-1:0]   row_q;
  logic [dimu_pkg::RC_W-1:0]   col_q;
  logic [dimu_pkg::RC_W-1:0]   col_d;
  logic [dimu_pkg::ADDR_W-1:0] row_base;
  logic [dimu_pkg::RC_W-1:0]   col_r, col_l, row_u, row_dn;
  logic [dimu_pkg::RC_W-1:0]   sel_row, sel_col;

  assign prod = dimu_pkg::PROD_W'(site_i) * dimu_pkg::PROD_W'(dimu_pkg::RECIP);

  // remainder from the registered quotient
  assign row_base = dimu_pkg::ADDR_W'(row_q) * dimu_pkg::ADDR_W'(dimu_pkg::SIDE);
  assign col_d    = dimu_pkg::RC_W'(dimu_pkg::ADDR_W'(site_i) - row_base);

  always_ff @(posedge clk_i) begin
    if (ctl_i.div_en) begin
      row_q <= prod[dimu_pkg::RECIP_SHIFT +: dimu_pkg::RC_W];
    end
    if (ctl_i.col_en) begin
      col_q <= col_d;
    end
  end

  // periodic wrap on all four sides
  always_comb begin
    col_r  = (col_q == dimu_pkg::RC_W'(dimu_pkg::SIDE - 1)) ? '0 : col_q + 1'b1;
    col_l  = (col_q == '0) ? dimu_pkg::RC_W'(dimu_pkg::SIDE - 1) : col_q - 1'b1;
    row_dn = (row_q == dimu_pkg::RC_W'(dimu_pkg::SIDE - 1)) ? '0 : row_q + 1'b1;
    row_u  = (row_q == '0) ? dimu_pkg::RC_W'(dimu_pkg::SIDE - 1) : row_q - 1'b1;
    case (ctl_i.step)
      dimu_pkg::STEP_RIGHT: begin
        sel_row = row_q;
        sel_col = col_r;
      end
      dimu_pkg::STEP_LEFT: begin
        sel_row = row_q;
        sel_col = col_l;
      end
      dimu_pkg::STEP_UP: begin
        sel_row = row_u;
        sel_col = col_q;
      end
      dimu_pkg::STEP_DOWN: begin
        sel_row = row_dn;
        sel_col = col_q;
      end
      default: begin
        sel_row = row_q;
        sel_col = col_q;
      end
    endcase
    addr_o = dimu_pkg::ADDR_W'(sel_row) * dimu_pkg::ADDR_W'(dimu_pkg::SIDE)
           + dimu_pkg::ADDR_W'(sel_col);
  end

endmodule

// ===== rtl/core/diluted_ising_metropolis_update_unit.sv =====
// top level of the diluted ising metropolis update unit
// depends on dimu_pkg, dimu_ram, dimu_nbr_addr
`timescale 1ns / 1ps

// Usage:
// A request word is taken at a rising edge where start is high and busy is
// low. req_type_i selects a site write, a site read, a threshold table load
// or a metropolis flip attempt at site_i with random_in_i.
// Each request gives exactly one result word: valid_o is high for one cycle
// with spin_out_o, flipped_o, neighbour_total_o and magnetization_o, and the
// word is taken at the edge that ends that cycle. The receiver cannot stall.
// Sequence: after the accepting edge a request passes S_DIV, S_COL, S_READ,
// S_COLLECT and S_EVAL before the result strobe; busy falls in the strobe
// cycle, so a new request may be taken there and not before. The pace is set
// by the single lattice ram port: a flip reads center and four neighbours one
// per cycle, after the registered row and column split, then writes back;
// the other kinds read only the center.
// Reset: the lattice is cleared by a pass over all SIDE*SIDE sites, one site
// per cycle, with busy high; magnetization is zero. Threshold entries are
// undefined until loaded.
module diluted_ising_metropolis_update_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [dimu_pkg::REQ_W-1:0]         req_type_i,
  input  logic [dimu_pkg::SITE_W-1:0]        site_i,
  input  logic signed [dimu_pkg::SPIN_W-1:0] spin_in_i,
  input  logic [dimu_pkg::SLOT_W-1:0]        table_slot_i,
  input  logic [dimu_pkg::THR_W-1:0]         threshold_in_i,
  input  logic [dimu_pkg::RND_W-1:0]         random_in_i,
  output logic                               valid_o,
  output logic signed [dimu_pkg::SPIN_W-1:0] spin_out_o,
  output logic                               flipped_o,
  output logic signed [dimu_pkg::NSUM_W-1:0] neighbour_total_o,
  output logic signed [dimu_pkg::MAG_W-1:0]  magnetization_o
);

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_DIV     = 3'd2;
  localparam logic [2:0] S_COL     = 3'd3;
  localparam logic [2:0] S_READ    = 3'd4;
  localparam logic [2:0] S_COLLECT = 3'd5;
  localparam logic [2:0] S_EVAL    = 3'd6;

  logic [2:0]                      state_q, state_d;
  logic [dimu_pkg::STEP_W-1:0]     step_q, step_d;
  logic [dimu_pkg::ADDR_W-1:0]     clr_q, clr_d;
  logic                            iss_q;
  logic [dimu_pkg::STEP_W-1:0]     iss_step_q;
  logic                            valid_q, valid_d;
  logic signed [dimu_pkg::MAG_W-1:0] magnet_q, magnet_d;

  logic [dimu_pkg::REQ_W-1:0]      req_q;
  logic [dimu_pkg::SITE_W-1:0]     site_q;
  logic [dimu_pkg::SPIN_W-1:0]     spin_in_q;
  logic [dimu_pkg::SLOT_W-1:0]     slot_q;
  logic [dimu_pkg::THR_W-1:0]      thr_q;
  logic [dimu_pkg::RND_W-1:0]      rnd_q;
  logic                            vld_q;
  logic [dimu_pkg::SPIN_W-1:0]     center_q;
  logic signed [dimu_pkg::NSUM_W-1:0] nsum_q;
  logic [dimu_pkg::THR_W-1:0]      table_q [dimu_pkg::NSLOTS];

  logic [dimu_pkg::SPIN_W-1:0]     spin_out_q;
  logic                            flipped_q;
  logic [dimu_pkg::NSUM_W-1:0]     ntot_q;

  logic                            accept;
  logic                            ram_we, ram_re;
  logic [dimu_pkg::ADDR_W-1:0]     ram_addr;
  logic [dimu_pkg::SPIN_W-1:0]     ram_wdata, ram_rdata;
  logic [dimu_pkg::ADDR_W-1:0]     nbr_addr;
  dimu_pkg::addr_ctl_t             addr_ctl;

  logic [dimu_pkg::SPIN_W-1:0]     spin_dec;
  logic [dimu_pkg::SLOT_W-1:0]     idx;
  logic                            flip_c;
  logic                            wr_site;
  logic [dimu_pkg::MAG_W-1:0]      ctr_ext, dec_ext;
  logic [dimu_pkg::SPIN_W-1:0]     spin_new;
  logic [dimu_pkg::THR_W-1:0]      thr_sat;

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);

  assign addr_ctl.div_en = (state_q == S_DIV);
  assign addr_ctl.col_en = (state_q == S_COL);
  assign addr_ctl.step   = step_q;

  dimu_nbr_addr u_nbr_addr (
    .clk_i  (clk_i),
    .ctl_i  (addr_ctl),
    .site_i (site_q),
    .addr_o (nbr_addr)
  );

  dimu_ram #(
    .WIDTH (dimu_pkg::SPIN_W),
    .DEPTH (dimu_pkg::NSITES)
  ) u_lattice (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // evaluation of the collected word
  always_comb begin
    // negative patterns store -1
    spin_dec = {spin_in_q[1], spin_in_q[1] | spin_in_q[0]};
    idx = dimu_pkg::SLOT_W'({nsum_q[dimu_pkg::NSUM_W-1], nsum_q}) + 5'd4
        + ((center_q == 2'b01) ? 5'd9 : 5'd0);
    flip_c = (req_q == dimu_pkg::REQ_FLIP) && vld_q && (center_q != 2'b00)
          && ({1'b0, rnd_q} < table_q[idx]);
    wr_site = (req_q == dimu_pkg::REQ_WRITE) && vld_q;
    ctr_ext = {{(dimu_pkg::MAG_W-2){center_q[1]}}, center_q};
    dec_ext = {{(dimu_pkg::MAG_W-2){spin_dec[1]}}, spin_dec};
    spin_new = wr_site ? spin_dec : (flip_c ? 2'(-center_q) : center_q);
    thr_sat = (thr_q > dimu_pkg::THR_ONE) ? dimu_pkg::THR_ONE : thr_q;
  end

  // sequencer and ram port
  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    clr_d     = clr_q;
    valid_d   = 1'b0;
    magnet_d  = magnet_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = nbr_addr;
    ram_wdata = spin_new;
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == dimu_pkg::ADDR_W'(dimu_pkg::NSITES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        state_d = S_COL;
      end
      S_COL: begin
        step_d  = dimu_pkg::STEP_CTR;
        state_d = vld_q ? S_READ : S_COLLECT;
      end
      S_READ: begin
        ram_re = 1'b1;
        if ((req_q == dimu_pkg::REQ_FLIP) && (step_q != dimu_pkg::STEP_DOWN)) begin
          step_d = step_q + 1'b1;
        end else begin
          state_d = S_COLLECT;
        end
      end
      S_COLLECT: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        ram_we   = wr_site || flip_c;
        ram_addr = dimu_pkg::ADDR_W'(site_q);
        valid_d  = 1'b1;
        if (wr_site) begin
          magnet_d = magnet_q + dec_ext - ctr_ext;
        end else if (flip_c) begin
          magnet_d = magnet_q - {ctr_ext[dimu_pkg::MAG_W-2:0], 1'b0};
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      step_q     <= dimu_pkg::STEP_CTR;
      clr_q      <= '0;
      iss_q      <= 1'b0;
      iss_step_q <= dimu_pkg::STEP_CTR;
      valid_q    <= 1'b0;
      magnet_q   <= '0;
    end else begin
      state_q    <= state_d;
      step_q     <= step_d;
      clr_q      <= clr_d;
      iss_q      <= ram_re;
      iss_step_q <= step_q;
      valid_q    <= valid_d;
      magnet_q   <= magnet_d;
    end
  end

  // request payload, read collection and result word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q     <= req_type_i;
      site_q    <= site_i;
      spin_in_q <= spin_in_i;
      slot_q    <= table_slot_i;
      thr_q     <= threshold_in_i;
      rnd_q     <= random_in_i;
      vld_q     <= (32'(site_i) < dimu_pkg::NSITES);
      center_q  <= '0;
      nsum_q    <= '0;
    end else if (iss_q) begin
      if (iss_step_q == dimu_pkg::STEP_CTR) begin
        center_q <= ram_rdata;
      end else begin
        nsum_q <= nsum_q + {{(dimu_pkg::NSUM_W-2){ram_rdata[1]}}, ram_rdata};
      end
    end
    if (state_q == S_EVAL) begin
      spin_out_q <= spin_new;
      flipped_q  <= flip_c;
      ntot_q     <= nsum_q;
      if ((req_q == dimu_pkg::REQ_TABLE)
          && (slot_q < dimu_pkg::SLOT_W'(dimu_pkg::NSLOTS))) begin
        table_q[slot_q] <= thr_sat;
      end
    end
  end

  assign valid_o           = valid_q;
  assign spin_out_o        = spin_out_q;
  assign flipped_o         = flipped_q;
  assign neighbour_total_o = ntot_q;
  assign magnetization_o   = magnet_q;

endmodule

// ===== rtl/core/dimu_checker.sv =====
// port-level checker for the ising update unit, bound to the top level
// depends on dimu_pkg and diluted_ising_metropolis_update_unit_assert.svh
`timescale 1ns / 1ps
`include "diluted_ising_metropolis_update_unit_assert.svh"

module dimu_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start,
  input logic                               busy,
  input logic                               valid_o,
  input logic signed [dimu_pkg::SPIN_W-1:0] spin_out_o,
  input logic                               flipped_o
);

  logic flip_ok;

  // a flipped site can never be a vacancy
  assign flip_ok = !(valid_o && flipped_o) || (spin_out_o != 2'sb00);

  // an accepted word makes the unit busy
  `DIMU_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "accept without busy")

  // result only shows once the work is done
  `DIMU_ASSERT(a_result_idle, clk_i, rst_ni, !valid_o || (!busy && $past(busy)), "early result")

  // one word in gives one word out
  `DIMU_ASSERT_NEXT(a_single_result, clk_i, rst_ni, valid_o, !valid_o, "repeated result strobe")

  `DIMU_ASSERT(a_flip_nonzero, clk_i, rst_ni, flip_ok, "flip onto vacancy")

endmodule

bind diluted_ising_metropolis_update_unit dimu_checker u_dimu_checker (.*);

// ===== tb/tb_diluted_ising_metropolis_update_unit.sv =====
// self-checking testbench for the diluted ising metropolis update unit
// depends on dimu_pkg and diluted_ising_metropolis_update_unit; a scoreboard class
// predicts each result word from its own lattice copy and checks the strobed outputs
`timescale 1ns / 1ps

module tb_diluted_ising_metropolis_update_unit;
  import dimu_pkg::*;

  localparam int unsigned RANDOM_WORDS  = 1625;
  localparam int unsigned CYCLE_LIMIT   = 250000;
  localparam int unsigned SETTLE_CYCLES = 16;

  typedef struct {
    logic signed [SPIN_W-1:0] spin;
    logic                     flip;
    logic signed [NSUM_W-1:0] nsum;
    logic signed [MAG_W-1:0]  mag;
  } outcome_t;

  class lattice_scoreboard;
    logic signed [SPIN_W-1:0] spins [NSITES];
    logic [THR_W-1:0]         thresholds [NSLOTS];
    logic signed [MAG_W-1:0]  magnet;
    outcome_t                 expected_outcomes [$];
    int                       errors;

    function new();
      foreach (spins[i]) spins[i] = '0;
      foreach (thresholds[i]) thresholds[i] = '0;
      magnet = '0;
      errors = 0;
    endfunction

    function void note_request(logic [REQ_W-1:0] kind, logic [SITE_W-1:0] site,
                               logic [SPIN_W-1:0] spin_raw, logic [SLOT_W-1:0] slot,
                               logic [THR_W-1:0] thr, logic [RND_W-1:0] rnd);
      int center, row, col, nsum, idx, stored;
      outcome_t res;
      center = int'(spins[site]);
      nsum = 0;
      res.flip = 1'b0;
      case (kind)
        REQ_WRITE: begin
          // both negative patterns store -1
          stored = (spin_raw == 2'b00) ? 0 : (spin_raw == 2'b01) ? 1 : -1;
          magnet = magnet + MAG_W'(stored - center);
          spins[site] = SPIN_W'(stored);
          center = stored;
        end
        REQ_TABLE: begin
          if (slot < NSLOTS) thresholds[slot] = (thr > THR_ONE) ? THR_ONE : thr;
        end
        REQ_FLIP: begin
          row = int'(site) / SIDE;
          col = int'(site) % SIDE;
          nsum = int'(spins[row * SIDE + (col + 1) % SIDE])
               + int'(spins[row * SIDE + (col + SIDE - 1) % SIDE])
               + int'(spins[((row + SIDE - 1) % SIDE) * SIDE + col])
               + int'(spins[((row + 1) % SIDE) * SIDE + col]);
          idx = (center > 0 ? 9 : 0) + nsum + 4;
          if (center != 0 && rnd < thresholds[idx]) begin
            magnet = magnet - MAG_W'(2 * center);
            center = -center;
            spins[site] = SPIN_W'(center);
            res.flip = 1'b1;
          end
        end
        default: begin
        end
      endcase
      res.spin = SPIN_W'(center);
      res.nsum = NSUM_W'(nsum);
      res.mag  = magnet;
      expected_outcomes.push_back(res);
    endfunction

    function void compare_field(string what, logic signed [MAG_W-1:0] want,
                                logic signed [MAG_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      end
    endfunction

    function void check_outcome(logic signed [SPIN_W-1:0] spin, logic flip,
                                logic signed [NSUM_W-1:0] nsum,
                                logic signed [MAG_W-1:0] mag);
      outcome_t want;
      if (expected_outcomes.size() == 0) begin
        errors++;
        $display("%0t result word with none expected: spin %0d flip %0d nsum %0d mag %0d",
                 $time, spin, flip, nsum, mag);
        return;
      end
      want = expected_outcomes.pop_front();
      compare_field("spin_out", want.spin, spin);
      compare_field("flipped", want.flip, flip);
      compare_field("neighbour_total", want.nsum, nsum);
      compare_field("magnetization", want.mag, mag);
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic [REQ_W-1:0]         req_type_i;
  logic [SITE_W-1:0]        site_i;
  logic signed [SPIN_W-1:0] spin_in_i;
  logic [SLOT_W-1:0]        table_slot_i;
  logic [THR_W-1:0]         threshold_in_i;
  logic [RND_W-1:0]         random_in_i;
  logic                     valid_o;
  logic signed [SPIN_W-1:0] spin_out_o;
  logic                     flipped_o;
  logic signed [NSUM_W-1:0] neighbour_total_o;
  logic signed [MAG_W-1:0]  magnetization_o;

  lattice_scoreboard board;
  int unsigned cycle_count = 0;

  diluted_ising_metropolis_update_unit DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .req_type_i        (req_type_i),
    .site_i            (site_i),
    .spin_in_i         (spin_in_i),
    .table_slot_i      (table_slot_i),
    .threshold_in_i    (threshold_in_i),
    .random_in_i       (random_in_i),
    .valid_o           (valid_o),
    .spin_out_o        (spin_out_o),
    .flipped_o         (flipped_o),
    .neighbour_total_o (neighbour_total_o),
    .magnetization_o   (magnetization_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // covers the reset clearing pass too
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o === 1'b1)
      board.check_outcome(spin_out_o, flipped_o, neighbour_total_o, magnetization_o);
  end

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_word(input logic [REQ_W-1:0] kind, input logic [SITE_W-1:0] site,
                           input logic [SPIN_W-1:0] spin, input logic [SLOT_W-1:0] slot,
                           input logic [THR_W-1:0] thr, input logic [RND_W-1:0] rnd);
    req_type_i     <= kind;
    site_i         <= site;
    spin_in_i      <= spin;
    table_slot_i   <= slot;
    threshold_in_i <= thr;
    random_in_i    <= rnd;
    start          <= 1'b1;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    board.note_request(kind, site, spin, slot, thr, rnd);
    @(negedge clk_i);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (board.expected_outcomes.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    int unsigned roll;
    logic [REQ_W-1:0]  kind;
    logic [SITE_W-1:0] site;
    logic [SPIN_W-1:0] spin;
    logic [SLOT_W-1:0] slot;
    logic [THR_W-1:0]  thr;
    logic [RND_W-1:0]  rnd;

    board          = new();
    rst_ni         = 1'b0;
    start          = 1'b0;
    req_type_i     = REQ_READ;
    site_i         = '0;
    spin_in_i      = '0;
    table_slot_i   = '0;
    threshold_in_i = '0;
    random_in_i    = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // load every threshold before any attempt can look one up; slot 0 saturates
    for (int k = 0; k < NSLOTS; k++) begin
      thr = (k == 0) ? 17'h1FFFF : (k % 3 == 0) ? THR_ONE : (k % 3 == 1) ? 17'd32768 : 17'd0;
      send_word(REQ_TABLE, SITE_W'(k), '0, SLOT_W'(k), thr, '0);
    end
    send_word(REQ_TABLE, '0, '0, SLOT_W'(31), 17'd0, '0);
    send_word(REQ_WRITE, SITE_W'(0), 2'b10, '0, '0, '0);
    send_word(REQ_WRITE, SITE_W'(NSITES - 1), 2'b01, '0, '0, '0);
    send_word(REQ_WRITE, SITE_W'(SIDE - 1), 2'b11, '0, '0, '0);
    send_word(REQ_WRITE, SITE_W'((SIDE - 1) * SIDE), 2'b01, '0, '0, '0);
    send_word(REQ_READ, SITE_W'(0), '0, '0, '0, '0);
    // corner sites exercise the wrap in both directions
    send_word(REQ_FLIP, SITE_W'(0), '0, '0, '0, 16'h0000);
    send_word(REQ_FLIP, SITE_W'(NSITES - 1), '0, '0, '0, 16'hFFFF);
    send_word(REQ_FLIP, SITE_W'(5), '0, '0, '0, 16'h0000);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 2)
        drain_results();
      else if ((n < 300 || n >= 600) && $urandom_range(0, 99) < 16)
        pause_sender($urandom_range(1, 12));

      roll = $urandom_range(0, 99);
      kind = (roll < 35) ? REQ_WRITE : (roll < 45) ? REQ_READ :
             (roll < 52) ? REQ_TABLE : REQ_FLIP;
      // mostly a small patch around the corner so neighbours are populated
      if ($urandom_range(0, 4) == 0)
        site = SITE_W'($urandom_range(0, NSITES - 1));
      else
        site = SITE_W'((((SIDE - 2) + $urandom_range(0, 4)) % SIDE) * SIDE +
                       ((SIDE - 2) + $urandom_range(0, 4)) % SIDE);
      spin = SPIN_W'($urandom_range(0, 3));
      slot = ($urandom_range(0, 6) == 0) ? SLOT_W'($urandom_range(NSLOTS, 31)) :
                                           SLOT_W'($urandom_range(0, NSLOTS - 1));
      case ($urandom_range(0, 9))
        0, 1:    thr = '0;
        2, 3:    thr = THR_ONE;
        4:       thr = THR_W'($urandom_range(65537, 131071));
        default: thr = THR_W'($urandom_range(0, 65535));
      endcase
      rnd = RND_W'($urandom_range(0, 65535));
      send_word(kind, site, spin, slot, thr, rnd);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.errors == 0 && board.expected_outcomes.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
